>>> hw/rtl/plob_pkg.sv
package plob_pkg;

	localparam int LEVELS_DEF      = 32;
	localparam int PRICE_WIDTH_DEF = 32;
	localparam int QTY_WIDTH_DEF   = 32;

	// operation codes
	localparam logic [1:0] OP_UPDATE   = 2'd0;
	localparam logic [1:0] OP_BUY      = 2'd1;
	localparam logic [1:0] OP_SELL     = 2'd2;
	localparam logic [1:0] OP_SNAPSHOT = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	localparam int SNAP_LIMIT = 32;
	localparam int FRAC_W     = 16;
	localparam int VOL_W      = 53;
	localparam int LOTS_W     = VOL_W - FRAC_W;
	localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
	localparam logic [63:0] VOL_LOTS_MAX = 64'((64'd1 << LOTS_W) - 64'd1);
	localparam int DIV_NUM_W  = 64 + FRAC_W;

endpackage

>>> hw/rtl/price_level_order_book_unit.sv
// Price-level order book: asks kept ascending, bids descending, each side in a
// one-port-read memory of LEVELS {price, quantity} entries, one item in work at
// a time. An update scans the side level by level, then shifts the moved
// entries one at a time; a buy or sell query walks the levels in order,
// and a buy that ends inside a level adds a serial divide; a snapshot
// reads the book one rank at a time. Each result also waits for the output
// register to drain; a new item is taken while the last result still waits.
module price_level_order_book_unit #(
	parameter int LEVELS      = plob_pkg::LEVELS_DEF,
	parameter int PRICE_WIDTH = plob_pkg::PRICE_WIDTH_DEF,
	parameter int QTY_WIDTH   = plob_pkg::QTY_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [63:0] amount,
	input  logic [5:0]  level_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [52:0] volume_q16,
	output logic [63:0] sell_amount,
	output logic [32:0] mid_twice,
	output logic        mid_valid,
	output logic [31:0] ask_level_price,
	output logic [31:0] ask_level_quantity,
	output logic [31:0] bid_level_price,
	output logic [31:0] bid_level_quantity,
	output logic [1:0]  levels_present,
	output logic        last
);

	localparam int PW       = (PRICE_WIDTH < 32) ? PRICE_WIDTH : 32;
	localparam int QW       = (QTY_WIDTH < 32) ? QTY_WIDTH : 32;
	localparam int EW       = PW + QW;
	localparam int MW       = PW + QW;
	localparam int AW       = $clog2(LEVELS);
	localparam int CW       = $clog2(LEVELS + 1);
	localparam int SNAP_MAX = (LEVELS < plob_pkg::SNAP_LIMIT) ? LEVELS : plob_pkg::SNAP_LIMIT;
	localparam int NW       = plob_pkg::DIV_NUM_W;
	localparam int FW       = plob_pkg::FRAC_W;

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN, S_SCAN_WAIT, S_SCAN_CHK, S_DEC, S_SHIFT, S_SH_WAIT, S_SH_WR,
		S_PUT, S_WALK, S_WK_WAIT, S_WK_MUL, S_WK_ACC, S_DIV, S_SNAP, S_SN_WAIT,
		S_SN_DAT, S_EMIT
	} state_t;

	state_t state_q;

	logic [1:0]    op_q;
	logic          side_q;
	logic [PW-1:0] price_q;
	logic [QW-1:0] qty_q;
	logic [63:0]   amount_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] ask_cnt_q, bid_cnt_q;
	logic [PW-1:0] best_ask_q, best_bid_q;
	logic [CW-1:0] idx_q, pos_q;
	logic          match_q, dir_up_q;
	logic [AW-1:0] rd_q;
	logic [63:0]   cur_q, lots_q, sum_q, prod_q;
	logic [QW-1:0] cv_q, q_q;
	logic [PW-1:0] p_q;
	logic          sat_q;

	logic [1:0]    res_status_q;
	logic [52:0]   res_vol_q;
	logic [63:0]   res_sell_q;
	logic [31:0]   res_ap_q, res_aq_q, res_bp_q, res_bq_q;
	logic [1:0]    res_pres_q;
	logic          res_last_q;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [52:0]   vol_q;
	logic [63:0]   sell_q;
	logic [32:0]   mid_q;
	logic          mid_valid_q;
	logic [31:0]   ap_q, aq_q, bp_q, bq_q;
	logic [1:0]    pres_q;
	logic          last_q;

	// memory ports
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [EW-1:0] ask_rdata, bid_rdata, rdata;
	logic          use_ask;
	logic [CW-1:0] cnt;
	logic [PW-1:0] ep;
	logic [QW-1:0] eq;
	logic          better;

	// walk arithmetic
	logic [63:0]   rem64;
	logic [QW-1:0] rem_v;
	logic [QW-1:0] mul_b;
	logic [MW-1:0] mul_prod;
	logic [64:0]   sum_ext;
	logic          sum_sat;
	logic          div_start, div_busy, div_done;
	logic [NW-1:0] div_quot;
	logic [63:0]   lots_div;
	logic [CW-1:0] n_clamp;
	logic [32:0]   mid_now;
	logic          mid_ok;

	always_comb begin
		case (op_q)
			plob_pkg::OP_UPDATE: use_ask = side_q;
			plob_pkg::OP_BUY:    use_ask = 1'b1;
			default:             use_ask = 1'b0;
		endcase
	end

	assign cnt    = use_ask ? ask_cnt_q : bid_cnt_q;
	assign rdata  = use_ask ? ask_rdata : bid_rdata;
	assign ep     = rdata[EW-1:QW];
	assign eq     = rdata[QW-1:0];
	assign better = side_q ? (ep < price_q) : (ep > price_q);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = {price_q, qty_q};
		case (state_q)
			S_SH_WR: begin
				we    = 1'b1;
				waddr = dir_up_q ? idx_q[AW-1:0] : AW'(idx_q - CW'(1));
				wdata = rdata;
			end
			S_PUT: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	plob_mem #(.DEPTH(LEVELS), .WIDTH(EW), .AW(AW)) u_ask_mem (
		.clk   (clk),
		.we    (we && use_ask),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q),
		.rdata (ask_rdata)
	);

	plob_mem #(.DEPTH(LEVELS), .WIDTH(EW), .AW(AW)) u_bid_mem (
		.clk   (clk),
		.we    (we && !use_ask),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_q),
		.rdata (bid_rdata)
	);

	assign rem64    = amount_q - cur_q;
	assign rem_v    = qty_q - cv_q;
	assign mul_b    = (op_q == plob_pkg::OP_BUY) ? eq : ((eq > rem_v) ? rem_v : eq);
	assign mul_prod = MW'(ep) * MW'(mul_b);
	assign sum_ext  = {1'b0, sum_q} + {1'b0, prod_q};
	assign sum_sat  = sum_ext[64];

	assign div_start = (state_q == S_WK_ACC) && (op_q == plob_pkg::OP_BUY) &&
	                   (p_q != '0) && (prod_q > rem64);

	plob_div #(.NW(NW), .DW(PW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({rem64, {FW{1'b0}}}),
		.divisor  (p_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// wraps at 64 bits like the accumulation it extends
	assign lots_div = lots_q + div_quot[NW-1:FW];

	assign n_clamp = (int'(level_count) > SNAP_MAX) ? CW'(SNAP_MAX) : CW'(level_count);
	assign mid_ok  = (ask_cnt_q != '0) && (bid_cnt_q != '0);
	assign mid_now = mid_ok ? (33'(best_ask_q) + 33'(best_bid_q)) : 33'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= plob_pkg::OP_UPDATE;
			side_q       <= 1'b0;
			price_q      <= '0;
			qty_q        <= '0;
			amount_q     <= '0;
			n_q          <= '0;
			ask_cnt_q    <= '0;
			bid_cnt_q    <= '0;
			best_ask_q   <= '0;
			best_bid_q   <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			match_q      <= 1'b0;
			dir_up_q     <= 1'b0;
			rd_q         <= '0;
			cur_q        <= '0;
			lots_q       <= '0;
			sum_q        <= '0;
			prod_q       <= '0;
			cv_q         <= '0;
			q_q          <= '0;
			p_q          <= '0;
			sat_q        <= 1'b0;
			res_status_q <= plob_pkg::ST_OK;
			res_vol_q    <= '0;
			res_sell_q   <= '0;
			res_ap_q     <= '0;
			res_aq_q     <= '0;
			res_bp_q     <= '0;
			res_bq_q     <= '0;
			res_pres_q   <= '0;
			res_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= plob_pkg::ST_OK;
			vol_q        <= '0;
			sell_q       <= '0;
			mid_q        <= '0;
			mid_valid_q  <= 1'b0;
			ap_q         <= '0;
			aq_q         <= '0;
			bp_q         <= '0;
			bq_q         <= '0;
			pres_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			// the emit state reloads the output register itself
			if (out_valid_q && out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			// keep a copy of each side's top entry for the mid price
			if (we && waddr == '0) begin
				if (use_ask) begin
					best_ask_q <= wdata[EW-1:QW];
				end else begin
					best_bid_q <= wdata[EW-1:QW];
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= operation;
						side_q       <= side;
						price_q      <= price[PW-1:0];
						qty_q        <= quantity[QW-1:0];
						amount_q     <= amount;
						n_q          <= n_clamp;
						idx_q        <= '0;
						cur_q        <= '0;
						lots_q       <= '0;
						cv_q         <= '0;
						sum_q        <= '0;
						sat_q        <= 1'b0;
						res_status_q <= plob_pkg::ST_OK;
						res_vol_q    <= '0;
						res_sell_q   <= '0;
						res_ap_q     <= '0;
						res_aq_q     <= '0;
						res_bp_q     <= '0;
						res_bq_q     <= '0;
						res_pres_q   <= '0;
						res_last_q   <= 1'b1;
						case (operation)
							plob_pkg::OP_UPDATE: state_q <= S_SCAN;
							plob_pkg::OP_BUY:    state_q <= S_WALK;
							plob_pkg::OP_SELL:   state_q <= S_WALK;
							default:             state_q <= (n_clamp == '0) ? S_IDLE : S_SNAP;
						endcase
					end
				end

				S_SCAN: begin
					if (idx_q == cnt) begin
						pos_q   <= idx_q;
						match_q <= 1'b0;
						state_q <= S_DEC;
					end else begin
						rd_q    <= idx_q[AW-1:0];
						state_q <= S_SCAN_WAIT;
					end
				end

				S_SCAN_WAIT: state_q <= S_SCAN_CHK;

				S_SCAN_CHK: begin
					if (ep == price_q) begin
						pos_q   <= idx_q;
						match_q <= 1'b1;
						state_q <= S_DEC;
					end else if (better) begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN;
					end else begin
						pos_q   <= idx_q;
						match_q <= 1'b0;
						state_q <= S_DEC;
					end
				end

				S_DEC: begin
					if (match_q && qty_q != '0) begin
						state_q <= S_PUT;
					end else if (match_q) begin
						idx_q    <= pos_q + CW'(1);
						dir_up_q <= 1'b0;
						state_q  <= S_SHIFT;
					end else if (qty_q == '0) begin
						state_q <= S_EMIT;
					end else if (cnt == CW'(LEVELS)) begin
						res_status_q <= plob_pkg::ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						idx_q    <= cnt;
						dir_up_q <= 1'b1;
						state_q  <= S_SHIFT;
					end
				end

				S_SHIFT: begin
					if (dir_up_q) begin
						if (idx_q > pos_q) begin
							rd_q    <= AW'(idx_q - CW'(1));
							state_q <= S_SH_WAIT;
						end else begin
							state_q <= S_PUT;
						end
					end else if (idx_q < cnt) begin
						rd_q    <= idx_q[AW-1:0];
						state_q <= S_SH_WAIT;
					end else begin
						// removal done: drop the last entry
						if (side_q) begin
							ask_cnt_q <= ask_cnt_q - CW'(1);
						end else begin
							bid_cnt_q <= bid_cnt_q - CW'(1);
						end
						state_q <= S_EMIT;
					end
				end

				S_SH_WAIT: state_q <= S_SH_WR;

				S_SH_WR: begin
					idx_q   <= dir_up_q ? (idx_q - CW'(1)) : (idx_q + CW'(1));
					state_q <= S_SHIFT;
				end

				S_PUT: begin
					if (!match_q) begin
						if (side_q) begin
							ask_cnt_q <= ask_cnt_q + CW'(1);
						end else begin
							bid_cnt_q <= bid_cnt_q + CW'(1);
						end
					end
					state_q <= S_EMIT;
				end

				S_WALK: begin
					if (idx_q < cnt && ((op_q == plob_pkg::OP_BUY) ? (cur_q < amount_q)
					                                             : (cv_q < qty_q))) begin
						rd_q    <= idx_q[AW-1:0];
						state_q <= S_WK_WAIT;
					end else begin
						if (op_q == plob_pkg::OP_BUY) begin
							res_status_q <= (cur_q < amount_q) ? plob_pkg::ST_EXHAUSTED
							                                   : plob_pkg::ST_OK;
							res_vol_q    <= (lots_q > plob_pkg::VOL_LOTS_MAX) ? plob_pkg::VOL_MAX
							                : {lots_q[plob_pkg::LOTS_W-1:0], {FW{1'b0}}};
						end else begin
							res_status_q <= sat_q ? plob_pkg::ST_SATURATED :
							                (cv_q < qty_q) ? plob_pkg::ST_EXHAUSTED
							                               : plob_pkg::ST_OK;
							res_sell_q   <= sum_q;
						end
						state_q <= S_EMIT;
					end
				end

				S_WK_WAIT: state_q <= S_WK_MUL;

				S_WK_MUL: begin
					p_q     <= ep;
					q_q     <= eq;
					prod_q  <= 64'(mul_prod);
					state_q <= S_WK_ACC;
				end

				S_WK_ACC: begin
					if (op_q == plob_pkg::OP_BUY) begin
						if (div_start) begin
							state_q <= S_DIV;
						end else begin
							cur_q   <= cur_q + prod_q;
							lots_q  <= lots_q + 64'(q_q);
							idx_q   <= idx_q + CW'(1);
							state_q <= S_WALK;
						end
					end else begin
						sum_q <= sum_sat ? {64{1'b1}} : sum_ext[63:0];
						sat_q <= sat_q || sum_sat;
						if (q_q > rem_v) begin
							// last level only partly sold
							res_status_q <= (sat_q || sum_sat) ? plob_pkg::ST_SATURATED
							                                   : plob_pkg::ST_OK;
							res_sell_q   <= sum_sat ? {64{1'b1}} : sum_ext[63:0];
							state_q      <= S_EMIT;
						end else begin
							cv_q    <= cv_q + q_q;
							idx_q   <= idx_q + CW'(1);
							state_q <= S_WALK;
						end
					end
				end

				S_DIV: begin
					if (div_done) begin
						res_status_q <= plob_pkg::ST_OK;
						res_vol_q    <= (lots_div > plob_pkg::VOL_LOTS_MAX) ? plob_pkg::VOL_MAX
						                : {lots_div[plob_pkg::LOTS_W-1:0], div_quot[FW-1:0]};
						state_q      <= S_EMIT;
					end
				end

				S_SNAP: begin
					rd_q    <= idx_q[AW-1:0];
					state_q <= S_SN_WAIT;
				end

				S_SN_WAIT: state_q <= S_SN_DAT;

				S_SN_DAT: begin
					res_ap_q   <= (idx_q < ask_cnt_q) ? 32'(ask_rdata[EW-1:QW]) : 32'd0;
					res_aq_q   <= (idx_q < ask_cnt_q) ? 32'(ask_rdata[QW-1:0]) : 32'd0;
					res_bp_q   <= (idx_q < bid_cnt_q) ? 32'(bid_rdata[EW-1:QW]) : 32'd0;
					res_bq_q   <= (idx_q < bid_cnt_q) ? 32'(bid_rdata[QW-1:0]) : 32'd0;
					res_pres_q <= {idx_q < bid_cnt_q, idx_q < ask_cnt_q};
					res_last_q <= (idx_q + CW'(1)) == n_q;
					state_q    <= S_EMIT;
				end

				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						vol_q       <= res_vol_q;
						sell_q      <= res_sell_q;
						mid_q       <= mid_now;
						mid_valid_q <= mid_ok;
						ap_q        <= res_ap_q;
						aq_q        <= res_aq_q;
						bp_q        <= res_bp_q;
						bq_q        <= res_bq_q;
						pres_q      <= res_pres_q;
						last_q      <= res_last_q;
						if (op_q == plob_pkg::OP_SNAPSHOT && !res_last_q) begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_SNAP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready           = (state_q == S_IDLE);
	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign volume_q16         = vol_q;
	assign sell_amount        = sell_q;
	assign mid_twice          = mid_q;
	assign mid_valid          = mid_valid_q;
	assign ask_level_price    = ap_q;
	assign ask_level_quantity = aq_q;
	assign bid_level_price    = bp_q;
	assign bid_level_quantity = bq_q;
	assign levels_present     = pres_q;
	assign last               = last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ask_cnt_q <= CW'(LEVELS) && bid_cnt_q <= CW'(LEVELS))
		else $error("level count beyond table depth");

	a_ask_step: assert property (@(posedge clk) disable iff (!arst_n)
		ask_cnt_q == $past(ask_cnt_q) || ask_cnt_q == $past(ask_cnt_q) + CW'(1) ||
		ask_cnt_q + CW'(1) == $past(ask_cnt_q))
		else $error("ask count moved by more than one");

	// an empty snapshot leaves the block idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready &&
		 !(operation == plob_pkg::OP_SNAPSHOT && n_clamp == '0)) |=> !in_ready)
		else $error("second beat taken while item in work");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");
`endif

endmodule

>>> hw/rtl/plob_mem.sv
module plob_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/plob_div.sv
module plob_div #(
	parameter int NW = 80,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   div_q;
	logic [NW-1:0]   num_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic            ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			num_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
				rem_q  <= '0;
				div_q  <= divisor;
				num_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
				num_q <= {num_q[NW-2:0], ge};
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = num_q;

endmodule

>>> tb/tb_price_level_order_book_unit.sv
`timescale 1ns / 100ps

module tb_price_level_order_book_unit;

	typedef struct {
		bit [1:0]  op;
		bit        side;
		bit [31:0] px;
		bit [31:0] qty;
		bit [63:0] amt;
		bit [5:0]  cnt;
	} order_t;

	typedef struct {
		bit [1:0]  status;
		bit [52:0] vol;
		bit [63:0] sell;
		bit [32:0] mid;
		bit        mid_ok;
		bit [31:0] ap, aq, bp, bq;
		bit [1:0]  pres;
		bit        lst;
	} book_res_t;

	localparam bit ASK = 1'b1;
	localparam bit BID = 1'b0;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  operation;
	logic        side;
	logic [31:0] price, quantity;
	logic [63:0] amount;
	logic [5:0]  level_count;
	logic [1:0]  status;
	logic [52:0] volume_q16;
	logic [63:0] sell_amount;
	logic [32:0] mid_twice;
	logic        mid_valid;
	logic [31:0] ask_level_price, ask_level_quantity, bid_level_price, bid_level_quantity;
	logic [1:0]  levels_present;
	logic        last;

	price_level_order_book_unit dut (.*);

	order_t    pending_orders[$];
	book_res_t expected_results[$];

	// book copy: index 1 asks ascending, index 0 bids descending
	bit [31:0] book_px[2][32];
	bit [31:0] book_qt[2][32];
	int        book_n[2];

	int  fails, orders_taken, results_seen, full_drops, exhausted_cnt, snap_ranks;
	bit  beat_taken;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic book_res_t blank_result();
		book_res_t r;
		r = '{default: 0};
		r.mid_ok = book_n[1] > 0 && book_n[0] > 0;
		if (r.mid_ok)
			r.mid = {1'b0, book_px[1][0]} + {1'b0, book_px[0][0]};
		r.lst = 1;
		return r;
	endfunction

	function automatic bit [1:0] update_level(bit s, bit [31:0] px, bit [31:0] qty);
		int n, i, pos;
		n = book_n[s];
		i = 0;
		while (i < n && book_px[s][i] != px) i++;
		if (qty == 0) begin
			if (i < n) begin
				for (int k = i; k < n - 1; k++) begin
					book_px[s][k] = book_px[s][k+1];
					book_qt[s][k] = book_qt[s][k+1];
				end
				book_n[s] = n - 1;
			end
			return plob_pkg::ST_OK;
		end
		if (i < n) begin
			book_qt[s][i] = qty;
			return plob_pkg::ST_OK;
		end
		if (n >= 32) return plob_pkg::ST_FULL;
		pos = 0;
		while (pos < n && (s ? book_px[s][pos] < px : book_px[s][pos] > px)) pos++;
		for (int k = n; k > pos; k--) begin
			book_px[s][k] = book_px[s][k-1];
			book_qt[s][k] = book_qt[s][k-1];
		end
		book_px[s][pos] = px;
		book_qt[s][pos] = qty;
		book_n[s] = n + 1;
		return plob_pkg::ST_OK;
	endfunction

	function automatic book_res_t buy_volume(bit [63:0] amt);
		book_res_t r;
		bit [63:0] spent, lots, frac, p, q, rem;
		bit done;
		int i;
		r = blank_result();
		spent = 0; lots = 0; frac = 0; done = 0; i = 0;
		while (i < book_n[1] && spent < amt && !done) begin
			p = 64'(book_px[1][i]);
			q = 64'(book_qt[1][i]);
			rem = amt - spent;
			if (p != 0 && q > rem / p) begin
				lots += rem / p;
				frac = ((rem % p) << plob_pkg::FRAC_W) / p;
				done = 1;
			end else begin
				spent += p * q;
				lots += q;
			end
			i++;
		end
		r.status = (!done && spent < amt) ? plob_pkg::ST_EXHAUSTED : plob_pkg::ST_OK;
		r.vol = (lots > plob_pkg::VOL_LOTS_MAX) ? plob_pkg::VOL_MAX :
			plob_pkg::VOL_W'((lots << plob_pkg::FRAC_W) + frac);
		return r;
	endfunction

	function automatic bit [63:0] sat_sum(bit [127:0] a, bit [127:0] b, inout bit sat);
		bit [127:0] s;
		s = a + b;
		if (s > 128'({64{1'b1}})) begin
			sat = 1;
			return {64{1'b1}};
		end
		return s[63:0];
	endfunction

	function automatic book_res_t sell_proceeds(bit [31:0] vol);
		book_res_t r;
		bit [63:0] sold, sum;
		bit [127:0] p, q;
		bit sat, done;
		int i;
		r = blank_result();
		sold = 0; sum = 0; sat = 0; done = 0; i = 0;
		while (i < book_n[0] && sold < vol && !done) begin
			p = 128'(book_px[0][i]);
			q = 128'(book_qt[0][i]);
			if (q > vol - sold) begin
				sum = sat_sum(sum, sat_sum(0, (vol - sold) * p, sat), sat);
				done = 1;
			end else begin
				sold += 64'(q);
				sum = sat_sum(sum, sat_sum(0, p * q, sat), sat);
			end
			i++;
		end
		r.sell = sum;
		if (sat) r.status = plob_pkg::ST_SATURATED;
		else if (!done && sold < vol) r.status = plob_pkg::ST_EXHAUSTED;
		return r;
	endfunction

	task automatic predict_order(order_t o);
		book_res_t r;
		int n;
		case (o.op)
			plob_pkg::OP_UPDATE: begin
				r.status = update_level(o.side, o.px, o.qty);
				if (r.status == plob_pkg::ST_FULL) full_drops++;
				begin
					bit [1:0] st;
					st = r.status;
					r = blank_result();
					r.status = st;
				end
				expected_results.push_back(r);
			end
			plob_pkg::OP_BUY: begin
				r = buy_volume(o.amt);
				if (r.status == plob_pkg::ST_EXHAUSTED) exhausted_cnt++;
				expected_results.push_back(r);
			end
			plob_pkg::OP_SELL: begin
				r = sell_proceeds(o.qty);
				if (r.status == plob_pkg::ST_EXHAUSTED) exhausted_cnt++;
				expected_results.push_back(r);
			end
			default: begin
				n = (o.cnt > plob_pkg::SNAP_LIMIT) ? plob_pkg::SNAP_LIMIT : int'(o.cnt);
				for (int i = 0; i < n; i++) begin
					r = blank_result();
					if (i < book_n[1]) begin
						r.ap = book_px[1][i];
						r.aq = book_qt[1][i];
						r.pres[0] = 1;
					end
					if (i < book_n[0]) begin
						r.bp = book_px[0][i];
						r.bq = book_qt[0][i];
						r.pres[1] = 1;
					end
					r.lst = (i == n - 1);
					expected_results.push_back(r);
					snap_ranks++;
				end
			end
		endcase
	endtask

	task automatic check_field(string name, bit [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	// accept input beats and predict
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_order('{operation, side, price, quantity, amount, level_count});
			orders_taken++;
			beat_taken = 1;
		end
	end

	// compare result beats
	always @(posedge clk) begin
		book_res_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result beat");
				fails++;
			end else begin
				e = expected_results.pop_front();
				check_field("status", 64'(e.status), 64'(status));
				check_field("volume_q16", 64'(e.vol), 64'(volume_q16));
				check_field("sell_amount", e.sell, sell_amount);
				check_field("mid_twice", 64'(e.mid), 64'(mid_twice));
				check_field("mid_valid", 64'(e.mid_ok), 64'(mid_valid));
				check_field("ask_level_price", 64'(e.ap), 64'(ask_level_price));
				check_field("ask_level_quantity", 64'(e.aq), 64'(ask_level_quantity));
				check_field("bid_level_price", 64'(e.bp), 64'(bid_level_price));
				check_field("bid_level_quantity", 64'(e.bq), 64'(bid_level_quantity));
				check_field("levels_present", 64'(e.pres), 64'(levels_present));
				check_field("last", 64'(e.lst), 64'(last));
			end
		end
	end

	// sender: hold the beat until taken, then maybe idle
	always @(negedge clk) begin
		order_t o;
		bit quiet;
		if (arst_n && (!in_valid || beat_taken)) begin
			beat_taken = 0;
			quiet = orders_taken >= 120 && orders_taken < 170;
			if (pending_orders.size() > 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
				o = pending_orders.pop_front();
				in_valid    <= 1;
				operation   <= o.op;
				side        <= o.side;
				price       <= o.px;
				quantity    <= o.qty;
				amount      <= o.amt;
				level_count <= o.cnt;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= (results_seen >= 150 && results_seen < 260) ||
				$urandom_range(0, 99) >= 26;
	end

	function automatic order_t mk(bit [1:0] op, bit s, bit [31:0] px, bit [31:0] qty,
		bit [63:0] amt, bit [5:0] cnt);
		order_t o;
		o = '{op, s, px, qty, amt, cnt};
		return o;
	endfunction

	function automatic order_t random_order();
		order_t o;
		int pick;
		o = mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom, $urandom,
			{$urandom, $urandom}, 6'($urandom_range(0, 63)));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			o.op = plob_pkg::OP_UPDATE;
			if ($urandom_range(0, 9) != 0) o.px = $urandom_range(980, 1040);
			if ($urandom_range(0, 4) == 0) o.qty = 0;
			else if ($urandom_range(0, 3) != 0) o.qty = $urandom_range(1, 500);
		end else if (pick < 70) begin
			o.op = plob_pkg::OP_BUY;
			case ($urandom_range(0, 3))
				0: o.amt = 64'($urandom_range(0, 5000));
				1: o.amt = 64'($urandom_range(0, 2000000));
				2: o.amt = {32'd0, $urandom};
				default: ;
			endcase
		end else if (pick < 85) begin
			o.op = plob_pkg::OP_SELL;
			if ($urandom_range(0, 2) != 0) o.qty = $urandom_range(0, 3000);
		end else begin
			o.op = plob_pkg::OP_SNAPSHOT;
			if ($urandom_range(0, 3) != 0) o.cnt = 6'($urandom_range(0, 8));
		end
		return o;
	endfunction

	initial begin
		arst_n = 0;
		in_valid = 0; out_ready = 0;
		operation = plob_pkg::OP_UPDATE; side = 0; price = 0; quantity = 0; amount = 0;
		level_count = 0;
		beat_taken = 0;
		book_n[0] = 0; book_n[1] = 0;

		// empty book, then a small crossed-in book with edge cases
		pending_orders.push_back(mk(plob_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 4));
		pending_orders.push_back(mk(plob_pkg::OP_BUY, 0, 0, 0, 64'd500, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SELL, 0, 0, 32'd7, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'd100, 32'd10, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'd102, 32'd5, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'd101, 32'd7, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK, 32'd105, 32'd3, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK, 32'd104, 32'd2, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK, 32'd0, 32'd4, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK, 32'd105, 32'd9, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'd99, 32'd0, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'd101, 32'd0, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_BUY, 0, 0, 0, 64'd0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SELL, 0, 0, 32'd0, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_BUY, 0, 0, 0, 64'd1000, 0));
		pending_orders.push_back(mk(plob_pkg::OP_BUY, 0, 0, 0, {64{1'b1}}, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SELL, 0, 0, 32'd12, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SELL, 0, 0, 32'hFFFF_FFFF, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SELL, 0, 0, 32'hFFFF_FFFF, 0, 0));
		pending_orders.push_back(mk(plob_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 6'd63));
		pending_orders.push_back(mk(plob_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 6'd0));
		pending_orders.push_back(mk(plob_pkg::OP_UPDATE, BID, 32'hFFFF_FFFF, 32'd0, 0, 0));

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// hold the sender until the directed part has fully drained
		wait (pending_orders.size() == 0 && !in_valid && expected_results.size() == 0);

		for (int k = 0; k < 126; k++) begin
			if (k == 60) begin
				// fill the ask side past capacity, then probe and clear it
				for (int j = 0; j < 34; j++)
					pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK,
						32'(2000 + j * 7), $urandom_range(1, 900), 0, 0));
				pending_orders.push_back(mk(plob_pkg::OP_SNAPSHOT, 0, 0, 0, 0, 6'd32));
				pending_orders.push_back(mk(plob_pkg::OP_BUY, 0, 0, 0, {32'd0, $urandom}, 0));
				for (int j = 0; j < 34; j++)
					pending_orders.push_back(mk(plob_pkg::OP_UPDATE, ASK,
						32'(2000 + j * 7), 0, 0, 0));
			end
			pending_orders.push_back(random_order());
		end

		wait (pending_orders.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (300) @(posedge clk);
		$display("covered %0d orders, %0d results, %0d snapshot ranks,", orders_taken,
			results_seen, snap_ranks);
		$display("%0d full-table drops, %0d exhausted queries", full_drops, exhausted_cnt);
		if (fails == 0 && expected_results.size() == 0) begin
			$display("tb_price_level_order_book_unit: PASS");
		end else begin
			$display("tb_price_level_order_book_unit: FAIL");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("tb_price_level_order_book_unit: FAIL");
		$finish;
	end

endmodule
